// ----- rtl/rv32_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rv32_pkg;

  typedef struct packed {
    logic        command;
    logic [13:0] load_address;
    logic [31:0] load_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pc_out;
    logic [7:0]  char_out;
  } out_word_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXIT     = 3'd1;
  localparam logic [2:0] ST_CHAR     = 3'd2;
  localparam logic [2:0] ST_EBREAK   = 3'd3;
  localparam logic [2:0] ST_ILLEGAL  = 3'd4;
  localparam logic [2:0] ST_SENTINEL = 3'd5;
  localparam logic [2:0] ST_HALTED   = 3'd6;

  localparam logic [31:0] SENTINEL_PC = 32'hffff_fff0;

  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_FWAIT,
    S_RS1,
    S_RS2,
    S_EXEC,
    S_MEM,
    S_MWAIT,
    S_WB,
    S_SYS1,
    S_SYS2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/rv32i_instruction_executor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                 | moves
// in       | in_valid/in_ready     | in_word_t: command, load_address, load_data
// out      | out_valid/out_ready   | out_word_t: status, pc_out, char_out
//
// one byte moves per access of the one-port byte memory: fetch and loads pass a
// request and wait state per byte (S_FETCH/S_FWAIT, S_MEM/S_MWAIT), stores one
// S_MEM each; the register file is a one-port memory read once per source register
// synchronous active-low reset clears state, pc, halted, out_valid, rf valid bits
// in_ready is high only when idle and the result register is empty
module rv32i_instruction_executor_core
  import rv32_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);
  localparam int AW = $clog2(MEM_BYTES);

  // byte memory, one port
  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] m_addr;
  logic          m_we;
  logic [7:0]    m_wdata, m_rdata_r;
  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wdata;
    m_rdata_r <= mem[m_addr];
  end

  // register file memory with per-entry valid bits (x1 reads the sentinel until written)
  logic [31:0] rf [32];
  logic [31:0] rf_valid_r;
  logic [4:0]  r_addr;
  logic        r_we;
  logic [31:0] r_wdata, r_rdata_r, r_raw_r;
  logic        r_ok_r;
  logic [4:0]  r_idx_r;
  always_ff @(posedge clk) begin
    if (r_we) rf[r_addr] <= r_wdata;
    r_raw_r <= rf[r_addr];
    r_idx_r <= r_addr;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) rf_valid_r <= '0;
    else if (r_we) rf_valid_r[r_addr] <= 1'b1;
  end
  assign r_ok_r = rf_valid_r[r_idx_r];
  always_comb begin
    if (r_idx_r == 5'd0) r_rdata_r = '0;
    else if (r_ok_r) r_rdata_r = r_raw_r;
    else if (r_idx_r == 5'd1) r_rdata_r = SENTINEL_PC;
    else r_rdata_r = '0;
  end

  state_t      state_r, state_nxt;
  logic [31:0] pc_r, pc_nxt, ins_r, ins_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [31:0] res_r, res_nxt, addr_r, addr_nxt, npc_r, npc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt, ov_r, ov_nxt;
  out_word_t   ow_r, ow_nxt;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, alu_b, alu_y, lw;
  logic        sub_sra, taken, illegal, wr;
  logic [1:0]  nbytes_m1;

  assign op = ins_r[6:0];
  assign rd = ins_r[11:7];
  assign f3 = ins_r[14:12];
  assign f7 = ins_r[31:25];
  assign imm_i = {{20{ins_r[31]}}, ins_r[31:20]};
  assign imm_s = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
  assign imm_b = {{20{ins_r[31]}}, ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign imm_j = {{12{ins_r[31]}}, ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
  assign alu_b = (op == OP_REG) ? b_r : imm_i;
  assign sub_sra = ((op == OP_REG) && f3 == 3'd0 && f7 == 7'h20) ||
                   (f3 == 3'd5 && f7 == 7'h20);

  rv32_alu u_alu (.f3(f3), .sub_sra(sub_sra), .a(a_r), .b(alu_b), .y(alu_y));

  always_comb begin
    case (f3)
      3'd0: taken = a_r == b_r;
      3'd1: taken = a_r != b_r;
      3'd4: taken = $signed(a_r) < $signed(b_r);
      3'd5: taken = $signed(a_r) >= $signed(b_r);
      3'd6: taken = a_r < b_r;
      default: taken = a_r >= b_r;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_LUI, OP_AUIPC, OP_JAL, OP_FENCE: illegal = 1'b0;
      OP_JALR: illegal = f3 != 3'd0;
      OP_BRANCH: illegal = f3 == 3'd2 || f3 == 3'd3;
      OP_LOAD: illegal = f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7;
      OP_STORE: illegal = f3[2] || f3 == 3'd3;
      OP_IMM: illegal = (f3 == 3'd1 && f7 != 7'd0) ||
                        (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20);
      OP_REG: illegal = f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5));
      OP_SYSTEM: illegal = f3 != 3'd0 || ins_r[31:21] != 11'd0;
      default: illegal = 1'b1;
    endcase
  end

  assign wr = op == OP_LUI || op == OP_AUIPC || op == OP_JAL || op == OP_JALR ||
              op == OP_LOAD || op == OP_IMM || op == OP_REG;
  assign nbytes_m1 = (op == OP_LOAD || op == OP_STORE) ?
                     (f3[1] ? 2'd3 : (f3[0] ? 2'd1 : 2'd0)) : 2'd3;

  // load extension
  always_comb begin
    case (f3)
      3'd0: lw = {{24{res_r[7]}}, res_r[7:0]};
      3'd1: lw = {{16{res_r[15]}}, res_r[15:0]};
      3'd4: lw = {24'd0, res_r[7:0]};
      3'd5: lw = {16'd0, res_r[15:0]};
      default: lw = res_r;
    endcase
  end

  logic [31:0] baddr;
  assign baddr = addr_r + {30'd0, cnt_r};

  function automatic out_word_t mk(input logic [2:0] s, input logic [31:0] p,
                                   input logic [7:0] c);
    mk.status = s;
    mk.pc_out = p;
    mk.char_out = c;
  endfunction

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r; ins_nxt = ins_r; a_nxt = a_r; b_nxt = b_r;
    res_nxt = res_r; addr_nxt = addr_r; npc_nxt = npc_r; cnt_nxt = cnt_r;
    halted_nxt = halted_r; ov_nxt = ov_r; ow_nxt = ow_r;
    m_addr = baddr[AW-1:0]; m_we = 1'b0; m_wdata = '0;
    r_addr = ins_r[19:15]; r_we = 1'b0; r_wdata = res_r;
    in_ready = (state_r == S_IDLE) && !ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (!in_word.command) begin
            addr_nxt = {16'd0, in_word.load_address, 2'b00};
            res_nxt = in_word.load_data;
            cnt_nxt = '0;
            state_nxt = S_LOAD;
          end else if (halted_r) begin
            ow_nxt = mk(ST_HALTED, pc_r, 8'd0);
            ov_nxt = 1'b1;
          end else begin
            addr_nxt = pc_r;
            cnt_nxt = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_LOAD: begin
        m_we = 1'b1;
        m_wdata = res_r[8*cnt_r +: 8];
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          ow_nxt = mk(ST_OK, pc_r, 8'd0);
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: state_nxt = S_FWAIT;
      S_FWAIT: begin
        ins_nxt[8*cnt_r +: 8] = m_rdata_r;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_RS1;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_RS1: begin
        r_addr = ins_r[19:15];
        state_nxt = S_RS2;
      end
      S_RS2: begin
        a_nxt = r_rdata_r;
        r_addr = ins_r[24:20];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        b_nxt = r_rdata_r;
        state_nxt = S_WB;
        if (illegal) begin
          halted_nxt = 1'b1;
          ow_nxt = mk(ST_ILLEGAL, pc_r, 8'd0);
          state_nxt = S_DONE;
        end else begin
          npc_nxt = pc_r + 32'd4;
          unique case (op)
            OP_LUI:   res_nxt = {ins_r[31:12], 12'd0};
            OP_AUIPC: res_nxt = {ins_r[31:12], 12'd0} + pc_r;
            OP_JAL: begin
              res_nxt = pc_r + 32'd4;
              npc_nxt = pc_r + imm_j;
            end
            OP_JALR: begin
              res_nxt = pc_r + 32'd4;
              npc_nxt = (a_r + imm_i) & ~32'd1;
            end
            OP_LOAD: begin
              addr_nxt = a_r + imm_i;
              res_nxt = '0;
              cnt_nxt = '0;
              state_nxt = S_MEM;
            end
            OP_STORE: begin
              addr_nxt = a_r + imm_s;
              cnt_nxt = '0;
              state_nxt = S_MEM;
            end
            OP_SYSTEM: begin
              if (ins_r[20]) begin
                halted_nxt = 1'b1;
                ow_nxt = mk(ST_EBREAK, pc_r, 8'd0);
                state_nxt = S_DONE;
              end else begin
                r_addr = 5'd10;
                state_nxt = S_SYS1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MEM: begin
        if (op == OP_STORE) begin
          m_we = 1'b1;
          m_wdata = b_r[8*cnt_r +: 8];
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == nbytes_m1) state_nxt = S_WB;
        end else begin
          state_nxt = S_MWAIT;
        end
      end
      S_MWAIT: begin
        res_nxt[8*cnt_r +: 8] = m_rdata_r;
        cnt_nxt = cnt_r + 2'd1;
        state_nxt = (cnt_r == nbytes_m1) ? S_WB : S_MEM;
      end
      S_SYS1: begin
        r_addr = 5'd11;
        a_nxt = r_rdata_r;
        state_nxt = S_SYS2;
      end
      S_SYS2: begin
        ow_nxt = mk(ST_OK, 32'd0, 8'd0);
        if (a_r == 32'd0) begin
          ow_nxt.status = ST_EXIT;
          halted_nxt = 1'b1;
        end else if (a_r == 32'd1) begin
          ow_nxt.status = ST_CHAR;
          ow_nxt.char_out = r_rdata_r[7:0];
        end
        pc_nxt = npc_r;
        ow_nxt.pc_out = npc_r;
        if (npc_r == SENTINEL_PC) begin
          halted_nxt = 1'b1;
          if (ow_nxt.status == ST_OK) ow_nxt.status = ST_SENTINEL;
        end
        state_nxt = S_DONE;
      end
      S_WB: begin
        if (wr && rd != 5'd0) begin
          r_addr = rd;
          r_we = 1'b1;
          // alu operands are both settled by now
          r_wdata = (op == OP_LOAD) ? lw :
                    ((op == OP_IMM || op == OP_REG) ? alu_y : res_r);
        end
        pc_nxt = (op == OP_BRANCH) ? (taken ? pc_r + imm_b : pc_r + 32'd4) : npc_r;
        ow_nxt = mk(ST_OK, pc_nxt, 8'd0);
        if (pc_nxt == SENTINEL_PC) begin
          halted_nxt = 1'b1;
          ow_nxt.status = ST_SENTINEL;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0;
      halted_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      halted_r <= halted_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt; a_r <= a_nxt; b_r <= b_nxt; res_r <= res_nxt;
    addr_r <= addr_nxt; npc_r <= npc_nxt; cnt_r <= cnt_nxt; ow_r <= ow_nxt;
  end

  assign out_valid = ov_r;
  assign out_word = ow_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_halt_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && state_r == S_IDLE) |=> halted_r) else $error("halt cleared");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire

// ----- rtl/rv32_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rv32_alu
  import rv32_pkg::*;
(
  input  wire logic [2:0]  f3,
  input  wire logic        sub_sra,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);
  logic [4:0] sh;
  assign sh = b[4:0];

  always_comb begin
    case (f3)
      3'd0: y = sub_sra ? a - b : a + b;
      3'd1: y = a << sh;
      3'd2: y = {31'd0, $signed(a) < $signed(b)};
      3'd3: y = {31'd0, a < b};
      3'd4: y = a ^ b;
      3'd5: y = sub_sra ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: y = a | b;
      default: y = a & b;
    endcase
  end
endmodule
`default_nettype wire
